// ===== design/pcsd_pkg.sv =====
// Package for the 5-bit prefix-code symbol decoder.
// Holds the result word type, symbol width codes, the code tree walk table and
// the modulo-5 helper. No dependencies.
package pcsd_pkg;

    // bit count codes carried in symbol_bits
    localparam logic [2:0] SYM_BITS = 3'd5;
    localparam logic [2:0] RAW_BITS = 3'd1;

    // walk entry: bit 5 marks a leaf, low 5 bits hold symbol or next node
    localparam int LEAF_POS = 5;

    typedef logic [5:0] walk_t;

    // one result word
    typedef struct packed {
        logic [4:0] symbol;
        logic [2:0] symbol_bits;
        logic       last;
    } res_t;

    // child lookup: node 0 is the root, unknown nodes fall back to the root row
    function automatic walk_t tree_walk(input logic [4:0] node, input logic bit_in);
        logic [5:0] c0;
        logic [5:0] c1;
        begin
            case (node)
                5'd0:    begin c0 = 6'd1;        c1 = 6'd2;        end
                5'd1:    begin c0 = 6'd3;        c1 = 6'd4;        end
                5'd2:    begin c0 = 6'd5;        c1 = 6'd6;        end
                5'd3:    begin c0 = 6'h20 | 6'd0;  c1 = 6'd7;      end
                5'd4:    begin c0 = 6'd8;        c1 = 6'd9;        end
                5'd5:    begin c0 = 6'd10;       c1 = 6'd11;       end
                5'd6:    begin c0 = 6'd12;       c1 = 6'd13;       end
                5'd7:    begin c0 = 6'h20 | 6'd1;  c1 = 6'h20 | 6'd2;  end
                5'd8:    begin c0 = 6'h20 | 6'd4;  c1 = 6'h20 | 6'd8;  end
                5'd9:    begin c0 = 6'h20 | 6'd16; c1 = 6'd14;     end
                5'd10:   begin c0 = 6'd15;       c1 = 6'd16;       end
                5'd11:   begin c0 = 6'd17;       c1 = 6'd18;       end
                5'd12:   begin c0 = 6'd19;       c1 = 6'd20;       end
                5'd13:   begin c0 = 6'd21;       c1 = 6'd22;       end
                5'd14:   begin c0 = 6'h20 | 6'd3;  c1 = 6'h20 | 6'd6;  end
                5'd15:   begin c0 = 6'h20 | 6'd5;  c1 = 6'h20 | 6'd12; end
                5'd16:   begin c0 = 6'h20 | 6'd10; c1 = 6'h20 | 6'd9;  end
                5'd17:   begin c0 = 6'h20 | 6'd24; c1 = 6'h20 | 6'd20; end
                5'd18:   begin c0 = 6'h20 | 6'd18; c1 = 6'h20 | 6'd17; end
                5'd19:   begin c0 = 6'h20 | 6'd28; c1 = 6'h20 | 6'd25; end
                5'd20:   begin c0 = 6'h20 | 6'd26; c1 = 6'h20 | 6'd7;  end
                5'd21:   begin c0 = 6'd23;       c1 = 6'd24;       end
                5'd22:   begin c0 = 6'd25;       c1 = 6'd26;       end
                5'd23:   begin c0 = 6'h20 | 6'd11; c1 = 6'h20 | 6'd13; end
                5'd24:   begin c0 = 6'h20 | 6'd14; c1 = 6'h20 | 6'd19; end
                5'd25:   begin c0 = 6'h20 | 6'd22; c1 = 6'd27;     end
                5'd26:   begin c0 = 6'd28;       c1 = 6'd29;       end
                5'd27:   begin c0 = 6'h20 | 6'd21; c1 = 6'h20 | 6'd30; end
                5'd28:   begin c0 = 6'h20 | 6'd29; c1 = 6'h20 | 6'd23; end
                5'd29:   begin c0 = 6'h20 | 6'd15; c1 = 6'd30;     end
                5'd30:   begin c0 = 6'h20 | 6'd27; c1 = 6'h20 | 6'd31; end
                default: begin c0 = 6'd1;        c1 = 6'd2;        end
            endcase
            return bit_in ? c1 : c0;
        end
    endfunction

    // x mod 5 using 16 = 1 (mod 5): fold nibbles, fold again, then trim
    function automatic logic [2:0] mod5_16(input logic [15:0] x);
        logic [5:0] s;
        logic [4:0] t;
        begin
            s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[15:12]);
            t = 5'(s[5:4]) + 5'(s[3:0]);
            if (t >= 5'd15)
                t = t - 5'd15;
            else if (t >= 5'd10)
                t = t - 5'd10;
            else if (t >= 5'd5)
                t = t - 5'd5;
            return t[2:0];
        end
    endfunction

endpackage

// ===== design/prefix_code_5bit_symbol_decoder.sv =====
// Top level of the 5-bit prefix-code symbol decoder: tree walk, bit counter,
// raw tail pass-through and a two-word output buffer. Depends on pcsd_pkg.
//
//  channel   direction  signals                                  role
//  in        sink       in_valid, in_ready, code_bit             one stream bit per word
//  out       source     out_valid, out_ready, symbol,            symbol or raw bit
//                       symbol_bits, last
//  cfg       sink       cfg_wr_en, cfg_wr_data                   total_bits register
//
// One bit is taken per cycle while in_ready is high; a result is registered into the
// main output register, or into the skid register while the main word waits. The rate
// is set by the loop through the tree node and bit counter registers.
// Reset clears the tree position, the counter, the total and the buffer; there
// is no clearing pass. The output has a main register and a skid register, so
// in_ready drops only once two results wait to be taken.
module prefix_code_5bit_symbol_decoder #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        code_bit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  symbol,
    output logic [2:0]  symbol_bits,
    output logic        last
);

    localparam logic [32:0] CAP = (33'd1 << COUNT_BITS) - 33'd1;

    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] coded_reg;
    logic [COUNT_BITS-1:0] bits_done_reg;
    logic [COUNT_BITS-1:0] bits_done_next;
    logic [4:0]            tree_node_reg;
    logic [4:0]            tree_node_next;

    logic [32:0]           cfg_wide;
    logic [32:0]           cfg_sat;
    logic [COUNT_BITS-1:0] cfg_total;
    logic [COUNT_BITS-1:0] cfg_coded;

    logic                  in_fire;
    logic                  restart;
    logic [COUNT_BITS-1:0] done_eff;
    logic [4:0]            node_eff;
    logic [COUNT_BITS:0]   done_sum;
    pcsd_pkg::walk_t       walk_entry;
    pcsd_pkg::res_t        res_new;
    logic                  has_result;
    logic                  produce;

    pcsd_pkg::res_t        main_reg;
    pcsd_pkg::res_t        skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  out_fire;

    // saturate the written total to the counter range and strip the tail
    always_comb
    begin
        cfg_wide  = 33'(cfg_wr_data);
        cfg_sat   = (cfg_wide > CAP) ? CAP : cfg_wide;
        cfg_total = cfg_sat[COUNT_BITS-1:0];
        cfg_coded = cfg_total - COUNT_BITS'(pcsd_pkg::mod5_16(cfg_sat[15:0]));
    end

    // configuration register with derived codeword limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            coded_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            total_reg <= cfg_total;
            coded_reg <= cfg_coded;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // decode step for one stream bit
    always_comb
    begin
        restart        = (bits_done_reg >= total_reg);
        done_eff       = restart ? '0 : bits_done_reg;
        node_eff       = restart ? 5'd0 : tree_node_reg;
        walk_entry     = pcsd_pkg::tree_walk(node_eff, code_bit);
        res_new        = '0;
        has_result     = 1'b0;
        tree_node_next = 5'd0;
        bits_done_next = done_eff;
        done_sum       = {1'b0, done_eff};
        if (total_reg == '0)
        begin
            bits_done_next = '0;
        end
        else
        begin
            if (done_eff < coded_reg)
            begin
                if (!walk_entry[pcsd_pkg::LEAF_POS])
                begin
                    tree_node_next = walk_entry[4:0];
                end
                else
                begin
                    has_result          = 1'b1;
                    res_new.symbol      = walk_entry[4:0];
                    res_new.symbol_bits = pcsd_pkg::SYM_BITS;
                end
            end
            else
            begin
                has_result          = 1'b1;
                res_new.symbol      = {4'b0000, code_bit};
                res_new.symbol_bits = pcsd_pkg::RAW_BITS;
            end
            // one extra bit so a count that runs past the counter still closes the block
            if (has_result)
            begin
                done_sum       = {1'b0, done_eff} + (COUNT_BITS+1)'(res_new.symbol_bits);
                res_new.last   = (done_sum >= {1'b0, total_reg});
                bits_done_next = res_new.last ? '0 : done_sum[COUNT_BITS-1:0];
            end
        end
    end

    assign produce = in_fire && has_result;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_node_reg <= 5'd0;
            bits_done_reg <= '0;
        end
        else if (in_fire)
        begin
            tree_node_reg <= tree_node_next;
            bits_done_reg <= bits_done_next;
        end
    end

    // output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_valid_reg  <= skid_valid_reg || produce;
            skid_valid_reg <= 1'b0;
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer words
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (produce)
                main_reg <= res_new;
        end
        else if (produce)
        begin
            skid_reg <= res_new;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol      = main_reg.symbol;
    assign symbol_bits = main_reg.symbol_bits;
    assign last        = main_reg.last;

`ifndef NO_ASSERTIONS
    // skid word only held behind a main word
    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without main word");

    // tree position never leaves the internal nodes
    a_node_range: assert property (@(posedge clk) disable iff (!rst_n)
        tree_node_reg != 5'd31)
        else $error("tree node out of range");

    // a bit taken with zero total leaves the block at reset state
    a_zero_total: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && total_reg == '0) |=> (bits_done_reg == '0 && tree_node_reg == 5'd0))
        else $error("zero total did not clear state");

    // a closing result restarts the count
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && res_new.last) |=> (bits_done_reg == '0 && tree_node_reg == 5'd0))
        else $error("block end did not restart count");

    // shown words carry a legal width code
    a_width_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (symbol_bits == pcsd_pkg::SYM_BITS || symbol_bits == pcsd_pkg::RAW_BITS))
        else $error("bad symbol_bits code");
`endif

endmodule
